>>> rtl/core/smdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smdf_pkg: shared types and constants of the sliding median distance filter
// Field widths, the reset value of the ceiling register and the sequencer
// states used by the filter and its channel interfaces.
// ----------------------------------------------------------------------------
package smdf_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned DIST_W   = 10;

   localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 10'd450;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [DIST_W-1:0]   dist_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_LATCH,
      ST_SCAN,
      ST_RANK,
      ST_OUT
   } state_type;

endpackage : smdf_pkg
`default_nettype wire

>>> rtl/core/smdf_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smdf_req_if: request channel of the median distance filter
// Valid/ready handshake carrying one raw distance sample per request.
// ----------------------------------------------------------------------------
interface smdf_req_if
   import smdf_pkg::*;
   ();

   logic       valid;
   logic       ready;
   sample_type distance_sample;

   modport source (output valid, output distance_sample, input ready);
   modport sink   (input valid, input distance_sample, output ready);

endinterface : smdf_req_if
`default_nettype wire

>>> rtl/core/smdf_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smdf_rsp_if: response channel of the median distance filter
// Valid/ready handshake carrying one median distance per response.
// ----------------------------------------------------------------------------
interface smdf_rsp_if
   import smdf_pkg::*;
   ();

   logic     valid;
   logic     ready;
   dist_type median_distance;

   modport source (output valid, output median_distance, input ready);
   modport sink   (input valid, input median_distance, output ready);

endinterface : smdf_rsp_if
`default_nettype wire

>>> rtl/core/sliding_median_distance_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_median_distance_filter: median of the last WINDOW distance samples
// Clamps each sample to the ceiling register, stores it in a ring and finds
// the window median by rank counting with one shared pair of comparisons.
// ----------------------------------------------------------------------------
// Each accepted request is clamped to csr max_distance and written into a
// ring of WINDOW entries. The first WINDOW-1 requests only fill the ring.
// Every later request produces one response; the next request is taken
// only after that response has been loaded into the output register. Each
// candidate in turn is compared (< and <=) with every entry through the
// single read port of the ring, one entry per cycle, its rank is checked,
// and the response is then loaded into the output register once that
// register is free.
// The block takes no new request while a median is being worked out; a
// finished response waits in the output register without holding up the
// next request. The ring is never read before it has been completely
// written, so it needs no clearing after reset.
module sliding_median_distance_filter
   import smdf_pkg::*;
#(
   parameter int unsigned WINDOW = 5
) (
   input  wire logic     clock,
   input  wire logic     reset,
   smdf_req_if.sink      req_ch,
   smdf_rsp_if.source    rsp_ch,
   input  wire logic     csr_wr_en,
   input  wire dist_type csr_wr_data
);

   localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CNT_W = $clog2(WINDOW + 1);

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW);
   localparam logic [CNT_W-1:0] LO_RANK   = CNT_W'((WINDOW - 1) / 2);
   localparam logic [CNT_W-1:0] HI_RANK   = CNT_W'(WINDOW / 2);

   // sample ring
   dist_type ring_mem [WINDOW];
   dist_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] wpos_ff, wpos_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0] lt_ff, lt_in;
   logic [CNT_W-1:0] le_ff, le_in;
   dist_type max_ff;
   dist_type cand_ff, cand_in;
   dist_type lo_ff, lo_in;
   dist_type hi_ff, hi_in;
   dist_type median_ff, median_in;
   logic     rsp_valid_ff, rsp_valid_in;

   logic        accept;
   logic        rsp_load;
   dist_type    clamped;
   logic [DIST_W:0] mid_sum;

   assign accept = req_ch.valid && req_ch.ready;

   // clamp the raw sample to the ceiling
   assign clamped = (req_ch.distance_sample > {{(SAMPLE_W-DIST_W){1'b0}}, max_ff}) ?
                    max_ff : req_ch.distance_sample[DIST_W-1:0];

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // write the ring on accept, register the read port
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wpos_ff] <= clamped;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   // ceiling register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_DISTANCE_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and counters
   always_ff @(posedge clock) begin
      cand_idx_ff <= cand_idx_in;
      scan_ff     <= scan_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      cand_ff     <= cand_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      median_ff   <= median_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      cand_idx_in  = cand_idx_ff;
      scan_in      = scan_ff;
      lt_in        = lt_ff;
      le_in        = le_ff;
      cand_in      = cand_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      median_in    = median_ff;
      rd_addr      = '0;
      rsp_load     = 1'b0;
      req_ch.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept) begin
               wpos_in = (wpos_ff == IDX_LAST) ? '0 : wpos_ff + 1'b1;
               if (fill_ff != FILL_LAST) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  cand_idx_in = '0;
                  state_in    = ST_CAND;
               end
            end
         end
         // issue the read of the current candidate
         ST_CAND: begin
            rd_addr  = cand_idx_ff;
            state_in = ST_LATCH;
         end
         // hold the candidate, start the scan at entry zero
         ST_LATCH: begin
            cand_in  = rd_data_ff;
            rd_addr  = '0;
            scan_in  = CNT_W'(1);
            lt_in    = '0;
            le_in    = '0;
            state_in = ST_SCAN;
         end
         // count entries below and not above the candidate
         ST_SCAN: begin
            lt_in = lt_ff + CNT_W'(rd_data_ff <  cand_ff);
            le_in = le_ff + CNT_W'(rd_data_ff <= cand_ff);
            if (scan_ff == CNT_FULL) begin
               rd_addr  = (cand_idx_ff == IDX_LAST) ? '0 : cand_idx_ff + 1'b1;
               state_in = ST_RANK;
            end else begin
               rd_addr = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
         end
         // keep the candidate if it sits at a middle rank; advance
         ST_RANK: begin
            if (lt_ff <= LO_RANK && LO_RANK < le_ff) begin
               lo_in = cand_ff;
            end
            if (lt_ff <= HI_RANK && HI_RANK < le_ff) begin
               hi_in = cand_ff;
            end
            rd_addr = (cand_idx_ff == IDX_LAST) ? '0 : cand_idx_ff + 1'b1;
            if (cand_idx_ff == IDX_LAST) begin
               state_in = ST_OUT;
            end else begin
               cand_idx_in = cand_idx_ff + 1'b1;
               state_in    = ST_LATCH;
            end
         end
         // load the response once the output register is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load  = 1'b1;
               median_in = DIST_W'(mid_sum >> 1);
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.median_distance = median_ff;

   // the candidate always counts itself as not above
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RANK |-> le_ff != '0 && lt_ff < le_ff)
      else $error("rank counts inconsistent");

   // a request that completes the ring starts a median pass
   assert property (@(posedge clock) disable iff (reset)
      accept && fill_ff == FILL_LAST |=> !req_ch.ready && state_ff == ST_CAND)
      else $error("median pass not started");

   // a new response only comes from the output step
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> state_ff == ST_OUT && (!rsp_valid_ff || rsp_ch.ready))
      else $error("response loaded over a pending one");

   // fill count stays within the window
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_LAST)
      else $error("fill count overrun");

endmodule : sliding_median_distance_filter
`default_nettype wire
